>>> rtl/ethash_pkg.sv
// Package with shared types, constants and the sequencer state type for the node hash unit.
package ethash_pkg;

    localparam int unsigned DataWidth = 32;
    localparam logic [31:0] ModulusReset = 32'd1000000007;
    localparam logic [31:0] MultiplierReset = 32'd31;
    localparam logic [15:0] LeafMix = 16'hFEDC;
    localparam logic [15:0] BinaryMix = 16'hAAAA;

    localparam logic [0:0] RegModulus = 1'b0;
    localparam logic [0:0] RegMultiplier = 1'b1;

    localparam logic [1:0] ModeLeaf = 2'd0;
    localparam logic [1:0] ModeUnary = 2'd1;

    // States of the shared modular multiplier.
    typedef enum logic [1:0] {
        MUL_IDLE,
        MUL_RUN
    } mul_state_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CH_FWD,
        ST_CH_REV,
        ST_CH_POW,
        ST_LAST_CHK,
        ST_F1,
        ST_P1_BASE,
        ST_P1_SQ,
        ST_P1_MUL,
        ST_P2_BASE,
        ST_P2_SQ,
        ST_P2_MUL,
        ST_RP1,
        ST_F2,
        ST_I2,
        ST_RV,
        ST_MIX,
        ST_OUT
    } seq_state_t;

    typedef struct packed {
        logic        start;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] addend;
    } mul_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] result;
    } mul_rsp_t;

endpackage

>>> rtl/ethash_modmul.sv
// Bit-serial modular multiplier: (a*b + addend) mod m, one bit of b per cycle.
module ethash_modmul (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [31:0]         modulus,
    input  ethash_pkg::mul_req_t req,
    output ethash_pkg::mul_rsp_t rsp
);
    import ethash_pkg::*;

    mul_state_t  state_reg, state_next;
    logic [32:0] acc_reg, acc_next;
    logic [32:0] a_reg, a_next;
    logic [31:0] b_reg, b_next;
    logic [31:0] d_reg, d_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [32:0] m_ext;
    logic [33:0] dbl;
    logic [33:0] dbl_add;
    logic [32:0] dbl_red;
    logic [33:0] sum_raw;
    logic [32:0] a_red;

    // A zero modulus stands for 2^32.
    assign m_ext = (modulus == 32'd0) ? {1'b1, 32'd0} : {1'b0, modulus};

    always_comb
    begin
        a_red = ({1'b0, req.a} >= m_ext) ? ({1'b0, req.a} - m_ext) : {1'b0, req.a};
        dbl = {acc_reg, 1'b0};
        dbl_red = (dbl >= {1'b0, m_ext}) ? 33'(dbl - {1'b0, m_ext}) : dbl[32:0];
        sum_raw = {1'b0, dbl_red} + (b_reg[31] ? {1'b0, a_reg} : 34'd0)
                  + {33'd0, d_reg[31]};
        dbl_add = (sum_raw >= {1'b0, m_ext}) ? (sum_raw - {1'b0, m_ext}) : sum_raw;
        state_next = state_reg;
        acc_next = acc_reg;
        a_next = a_reg;
        b_next = b_reg;
        d_next = d_reg;
        cnt_next = cnt_reg;
        rsp.done = 1'b0;
        rsp.result = acc_reg[31:0];
        case (state_reg)
            MUL_IDLE:
            begin
                if (req.start)
                begin
                    // Horner over the bits of b and of the addend, most significant first.
                    acc_next = 33'd0;
                    a_next = a_red;
                    b_next = req.b;
                    d_next = req.addend;
                    cnt_next = 6'd0;
                    state_next = MUL_RUN;
                end
            end
            MUL_RUN:
            begin
                acc_next = dbl_add[32:0];
                b_next = {b_reg[30:0], 1'b0};
                d_next = {d_reg[30:0], 1'b0};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd31)
                begin
                    state_next = MUL_IDLE;
                end
            end
            default:
            begin
                state_next = MUL_IDLE;
            end
        endcase
        if (state_reg == MUL_IDLE && !req.start && cnt_reg == 6'd32)
        begin
            rsp.done = 1'b1;
        end
        if (state_reg == MUL_RUN && cnt_reg == 6'd31)
        begin
            cnt_next = 6'd32;
        end
        if (state_reg == MUL_IDLE && cnt_reg == 6'd32 && !req.start)
        begin
            cnt_next = 6'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MUL_IDLE;
            cnt_reg <= 6'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg <= a_next;
        b_reg <= b_next;
        d_reg <= d_next;
    end

endmodule

>>> rtl/expression_tree_poly_hash_unit.sv
// Top level of the expression-tree node hash: sequencer, state registers and output register.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------------
//  in      | input     | in_valid / in_ready  | mode, char_code, last_char, child triples
//  out     | output    | out_valid/ out_ready | forward, reverse, mixed, length, table hash
//  cfg     | input     | cfg_valid/ cfg_ready | cfg_index (0 modulus, 1 multiplier), data
//
// Every modular product goes through one bit-serial multiplier, so an ordinary character
// holds the input for three products, a decision state and the idle state that takes the
// next beat. The last character adds one product per child term, one multiplier
// reduction and 64 square-and-multiply steps per child power.
// Reset clears the sums, the count and the output valid flag and sets the power to one at once.
// The input is not taken while an item is in work or a result waits in the
// output register; a stalled output beat simply holds.
module expression_tree_poly_hash_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [6:0]  char_code,
    input  logic        last_char,
    input  logic [31:0] first_forward,
    input  logic [31:0] first_reverse,
    input  logic [31:0] first_length,
    input  logic [31:0] second_forward,
    input  logic [31:0] second_reverse,
    input  logic [31:0] second_length,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] forward_value,
    output logic [31:0] reverse_value,
    output logic [31:0] mixed_value,
    output logic [31:0] total_length,
    output logic [32:0] table_hash,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);
    import ethash_pkg::*;

    seq_state_t  state_reg, state_next;
    logic [31:0] modulus_reg, multiplier_reg;
    logic [31:0] fsum_reg, fsum_next;
    logic [31:0] rsum_reg, rsum_next;
    logic [31:0] rpow_reg, rpow_next;
    logic [31:0] count_reg, count_next;
    // Captured item.
    logic [1:0]  mode_reg;
    logic [6:0]  char_reg;
    logic        last_reg;
    logic [31:0] f1_reg, r1_reg, l1_reg, f2_reg, r2_reg, l2_reg;
    // Working registers for the last character.
    logic [31:0] fw_reg, fw_next;
    logic [31:0] init_reg, init_next;
    logic [31:0] pw_reg, pw_next;
    logic [31:0] base_reg, base_next;
    logic [31:0] exp_reg, exp_next;
    logic [5:0]  bit_reg, bit_next;
    logic        busy_reg;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] ofw_reg, orv_reg, omix_reg, olen_reg;
    logic [32:0] otab_reg;
    logic [31:0] ofw_next, orv_next, omix_next, olen_next;
    logic [32:0] otab_next;
    mul_req_t    req;
    mul_rsp_t    rsp;
    logic        take;
    logic [31:0] one_red;
    logic [32:0] len_sum;
    logic [31:0] mix_raw;
    logic [31:0] low_val;
    logic [31:0] rv_tmp;

    ethash_modmul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .modulus (modulus_reg),
        .req     (req),
        .rsp     (rsp)
    );

    assign in_ready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign take = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign one_red = (modulus_reg == 32'd1) ? 32'd0 : 32'd1;

    assign out_valid = out_valid_reg;
    assign forward_value = ofw_reg;
    assign reverse_value = orv_reg;
    assign mixed_value = omix_reg;
    assign total_length = olen_reg;
    assign table_hash = otab_reg;

    always_comb
    begin
        state_next = state_reg;
        fsum_next = fsum_reg;
        rsum_next = rsum_reg;
        rpow_next = rpow_reg;
        count_next = count_reg;
        fw_next = fw_reg;
        init_next = init_reg;
        pw_next = pw_reg;
        base_next = base_reg;
        exp_next = exp_reg;
        bit_next = bit_reg;
        out_valid_next = out_valid_reg;
        ofw_next = ofw_reg;
        orv_next = orv_reg;
        omix_next = omix_reg;
        olen_next = olen_reg;
        otab_next = otab_reg;
        req = '0;
        len_sum = 33'd0;
        mix_raw = 32'd0;
        low_val = 32'd0;
        rv_tmp = 32'd0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    state_next = ST_CH_FWD;
                end
            end
            ST_CH_FWD:
            begin
                // forward_sum * M + c
                req.a = fsum_reg;
                req.b = multiplier_reg;
                req.addend = {25'd0, char_reg};
                req.start = !busy_reg;
                if (rsp.done)
                begin
                    fsum_next = rsp.result;
                    state_next = ST_CH_REV;
                end
            end
            ST_CH_REV:
            begin
                // The character goes on the serial side so that it needs no reduction.
                req.a = rpow_reg;
                req.b = {25'd0, char_reg};
                req.addend = rsum_reg;
                req.start = !busy_reg;
                if (rsp.done)
                begin
                    rsum_next = rsp.result;
                    state_next = ST_CH_POW;
                end
            end
            ST_CH_POW:
            begin
                req.a = rpow_reg;
                req.b = multiplier_reg;
                req.start = !busy_reg;
                if (rsp.done)
                begin
                    rpow_next = rsp.result;
                    count_next = (count_reg == 32'hFFFF_FFFF) ? count_reg : count_reg + 32'd1;
                    state_next = ST_LAST_CHK;
                end
            end
            ST_LAST_CHK:
            begin
                fw_next = fsum_reg;
                init_next = 32'd0;
                if (!last_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (mode_reg == ModeLeaf)
                begin
                    state_next = ST_RV;
                end
                else
                begin
                    state_next = ST_F1;
                end
            end
            ST_F1:
            begin
                // fw += R * f1
                req.a = rpow_reg;
                req.b = f1_reg;
                req.addend = fw_reg;
                req.start = !busy_reg;
                if (rsp.done)
                begin
                    fw_next = rsp.result;
                    if (mode_reg == ModeUnary)
                    begin
                        init_next = r1_reg;
                        state_next = ST_RV;
                    end
                    else
                    begin
                        pw_next = one_red;
                        exp_next = l1_reg;
                        bit_next = 6'd0;
                        state_next = ST_P1_BASE;
                    end
                end
            end
            ST_P1_BASE, ST_P2_BASE:
            begin
                // The multiplier is reduced once before it is squared.
                req.a = one_red;
                req.b = multiplier_reg;
                req.start = !busy_reg;
                if (rsp.done)
                begin
                    base_next = rsp.result;
                    state_next = (state_reg == ST_P1_BASE) ? ST_P1_MUL : ST_P2_MUL;
                end
            end
            ST_P1_MUL, ST_P2_MUL:
            begin
                // Square-and-multiply, low exponent bit first.
                req.a = pw_reg;
                req.b = exp_reg[0] ? base_reg : one_red;
                req.start = !busy_reg;
                if (rsp.done)
                begin
                    pw_next = rsp.result;
                    state_next = (state_reg == ST_P1_MUL) ? ST_P1_SQ : ST_P2_SQ;
                end
            end
            ST_P1_SQ, ST_P2_SQ:
            begin
                req.a = base_reg;
                req.b = base_reg;
                req.start = !busy_reg;
                if (rsp.done)
                begin
                    base_next = rsp.result;
                    exp_next = {1'b0, exp_reg[31:1]};
                    bit_next = bit_reg + 6'd1;
                    if (bit_reg == 6'd31)
                    begin
                        state_next = (state_reg == ST_P1_SQ) ? ST_RP1 : ST_I2;
                    end
                    else
                    begin
                        state_next = (state_reg == ST_P1_SQ) ? ST_P1_MUL : ST_P2_MUL;
                    end
                end
            end
            ST_RP1:
            begin
                req.a = rpow_reg;
                req.b = pw_reg;
                req.start = !busy_reg;
                if (rsp.done)
                begin
                    pw_next = rsp.result;
                    state_next = ST_F2;
                end
            end
            ST_F2:
            begin
                req.a = pw_reg;
                req.b = f2_reg;
                req.addend = fw_reg;
                req.start = !busy_reg;
                if (rsp.done)
                begin
                    fw_next = rsp.result;
                    pw_next = one_red;
                    exp_next = l2_reg;
                    bit_next = 6'd0;
                    state_next = ST_P2_BASE;
                end
            end
            ST_I2:
            begin
                req.a = pw_reg;
                req.b = r1_reg;
                req.addend = r2_reg;
                req.start = !busy_reg;
                if (rsp.done)
                begin
                    init_next = rsp.result;
                    state_next = ST_RV;
                end
            end
            ST_RV:
            begin
                // A unary child's reverse hash may exceed the modulus, so it goes serial.
                req.a = rpow_reg;
                req.b = init_reg;
                req.addend = rsum_reg;
                req.start = !busy_reg;
                if (rsp.done)
                begin
                    init_next = rsp.result;
                    state_next = ST_MIX;
                end
            end
            ST_MIX:
            begin
                rv_tmp = init_reg;
                if (mode_reg == ModeLeaf)
                begin
                    mix_raw = fw_reg ^ {16'd0, LeafMix};
                end
                else if (mode_reg == ModeUnary)
                begin
                    mix_raw = fw_reg ^ rv_tmp;
                end
                else
                begin
                    mix_raw = (fw_reg & rv_tmp) ^ {16'd0, BinaryMix};
                end
                // mix_raw < 2^32 and fw,rv < m, but the mix can still reach or exceed m,
                // so a serial reduction in ST_OUT handles the general case.
                omix_next = mix_raw;
                ofw_next = fw_reg;
                orv_next = rv_tmp;
                len_sum = {1'b0, count_reg};
                if (mode_reg != ModeLeaf)
                begin
                    len_sum = {1'b0, count_reg} + {1'b0, l1_reg};
                    if (len_sum[32])
                    begin
                        len_sum = 33'h0_FFFF_FFFF;
                    end
                    if (mode_reg != ModeUnary)
                    begin
                        len_sum = {1'b0, len_sum[31:0]} + {1'b0, l2_reg};
                        if (len_sum[32])
                        begin
                            len_sum = 33'h0_FFFF_FFFF;
                        end
                    end
                end
                olen_next = len_sum[31:0];
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // Reduce the mix through the multiplier: 1 * mix mod m.
                req.a = one_red;
                req.b = omix_reg;
                req.start = !busy_reg;
                if (rsp.done)
                begin
                    omix_next = rsp.result;
                    low_val = 32'(ofw_reg * 32'd29) + 32'({orv_reg[27:0], 4'd0} * 32'd13);
                    otab_next = {1'b0, low_val} + {1'b0, (rsp.result & olen_reg) >> 3};
                    out_valid_next = 1'b1;
                    fsum_next = 32'd0;
                    rsum_next = 32'd0;
                    rpow_next = 32'd1;
                    count_next = 32'd0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            modulus_reg <= ModulusReset;
            multiplier_reg <= MultiplierReset;
            fsum_reg <= 32'd0;
            rsum_reg <= 32'd0;
            rpow_reg <= 32'd1;
            count_reg <= 32'd0;
            out_valid_reg <= 1'b0;
            busy_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fsum_reg <= fsum_next;
            rsum_reg <= rsum_next;
            rpow_reg <= rpow_next;
            count_reg <= count_next;
            out_valid_reg <= out_valid_next;
            // The multiplier is started once per step; busy drops when it answers.
            if (req.start)
            begin
                busy_reg <= 1'b1;
            end
            else if (rsp.done)
            begin
                busy_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == RegModulus)
                begin
                    modulus_reg <= cfg_data;
                end
                else
                begin
                    multiplier_reg <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            mode_reg <= mode;
            char_reg <= char_code;
            last_reg <= last_char;
            f1_reg <= first_forward;
            r1_reg <= first_reverse;
            l1_reg <= first_length;
            f2_reg <= second_forward;
            r2_reg <= second_reverse;
            l2_reg <= second_length;
        end
        fw_reg <= fw_next;
        init_reg <= init_next;
        pw_reg <= pw_next;
        base_reg <= base_next;
        exp_reg <= exp_next;
        bit_reg <= bit_next;
        ofw_reg <= ofw_next;
        orv_reg <= orv_next;
        omix_reg <= omix_next;
        olen_reg <= olen_next;
        otab_reg <= otab_next;
    end

endmodule

>>> rtl/ethash_checker.sv
// Port-level checker for the node hash unit, bound to the top level.
module ethash_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] forward_value
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(forward_value))
        else $error("output beat changed while stalled");

    a_no_take_pending: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken while a result waits");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second beat taken back to back");

    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !out_valid)
        else $error("result appeared one cycle after a beat");

endmodule

bind expression_tree_poly_hash_unit ethash_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .forward_value (forward_value)
);

>>> tb/expression_tree_poly_hash_unit_test.sv
// Self-checking testbench for the expression-tree node hash unit.
module expression_tree_poly_hash_unit_test;
    timeunit 1ns;
    timeprecision 1ps;
    import ethash_pkg::*;

    // One result beat as the block presents it.
    typedef struct {
        logic [31:0] fwd;
        logic [31:0] rev;
        logic [31:0] mix;
        logic [31:0] len;
        logic [32:0] tab;
    } node_hash_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  mode;
    logic [6:0]  char_code;
    logic        last_char;
    logic [31:0] first_forward;
    logic [31:0] first_reverse;
    logic [31:0] first_length;
    logic [31:0] second_forward;
    logic [31:0] second_reverse;
    logic [31:0] second_length;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] forward_value;
    logic [31:0] reverse_value;
    logic [31:0] mixed_value;
    logic [31:0] total_length;
    logic [32:0] table_hash;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [31:0] cfg_data;

    expression_tree_poly_hash_unit u_dut (.*);

    // Predictor state: a private copy of the configuration and the running sums.
    logic [31:0] cur_modulus;
    logic [31:0] cur_multiplier;
    logic [31:0] fwd_sum;
    logic [31:0] rev_sum;
    logic [31:0] pow_run;
    logic [31:0] chars_seen;

    node_hash_t  pending_hashes[$];
    int          mismatch_count;
    int          items_sent;
    longint      cycle_count;
    // The node generator biases the modes towards leaf and unary nodes.
    bit          out_stall_on;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Reduction by the configured modulus; a zero modulus means plain 32-bit wrap.
    function automatic logic [31:0] reduce(logic [63:0] x);
        logic [63:0] m;
        m = (cur_modulus == 0) ? 64'h1_0000_0000 : {32'd0, cur_modulus};
        return 32'(x % m);
    endfunction

    function automatic logic [31:0] mod_mul(logic [31:0] a, logic [31:0] b);
        return reduce({32'd0, a} * {32'd0, b});
    endfunction

    function automatic logic [31:0] mod_add(logic [31:0] a, logic [31:0] b);
        return reduce({32'd0, reduce({32'd0, a})} + {32'd0, reduce({32'd0, b})});
    endfunction

    // Multiplier raised to an exact 32-bit exponent by square and multiply.
    function automatic logic [31:0] base_power(logic [31:0] e);
        logic [31:0] r;
        logic [31:0] b;
        r = reduce(64'd1);
        b = reduce({32'd0, cur_multiplier});
        for (int k = 0; k < 32; k++)
        begin
            if (e[k])
                r = mod_mul(r, b);
            b = mod_mul(b, b);
        end
        return r;
    endfunction

    function automatic logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic void clear_sums();
        fwd_sum = 0;
        rev_sum = 0;
        pow_run = 1;
        chars_seen = 0;
    endfunction

    // Folds one accepted character into the sums and, on the last one, queues
    // the node hash that the block must produce.
    function automatic void fold_character();
        logic [31:0] fw;
        logic [31:0] rv;
        logic [31:0] init;
        logic [31:0] mix;
        logic [31:0] len;
        logic [31:0] low;
        node_hash_t  h;
        fwd_sum = reduce({32'd0, fwd_sum} * {32'd0, cur_multiplier} + {57'd0, char_code});
        rev_sum = mod_add(rev_sum, mod_mul({25'd0, char_code}, pow_run));
        pow_run = mod_mul(pow_run, cur_multiplier);
        chars_seen = sat_sum(chars_seen, 32'd1);
        if (!last_char)
            return;
        fw = reduce({32'd0, fwd_sum});
        init = 0;
        len = chars_seen;
        if (mode != ModeLeaf)
        begin
            fw = mod_add(fw, mod_mul(pow_run, first_forward));
            len = sat_sum(len, first_length);
            if (mode == ModeUnary)
                init = reduce({32'd0, first_reverse});
            else
            begin
                // Mode three behaves as binary.
                fw = mod_add(fw, mod_mul(mod_mul(pow_run, base_power(first_length)),
                    second_forward));
                init = mod_add(second_reverse, mod_mul(base_power(second_length),
                    first_reverse));
                len = sat_sum(len, second_length);
            end
        end
        rv = mod_add(mod_mul(init, pow_run), rev_sum);
        if (mode == ModeLeaf)
            mix = reduce({32'd0, fw ^ {16'd0, LeafMix}});
        else if (mode == ModeUnary)
            mix = reduce({32'd0, fw ^ rv});
        else
            mix = reduce({32'd0, (fw & rv) ^ {16'd0, BinaryMix}});
        low = 32'({32'd0, fw} * 64'd29 + {32'd0, rv << 4} * 64'd13);
        h.fwd = fw;
        h.rev = rv;
        h.mix = mix;
        h.len = len;
        h.tab = {1'b0, low} + {1'b0, (mix & len) >> 3};
        pending_hashes.push_back(h);
        clear_sums();
    endfunction

    task automatic report_mismatch(string what, logic [32:0] got, logic [32:0] want);
        $display("ERROR %0s: got %h want %h", what, got, want);
        mismatch_count++;
    endtask

    // Gap length: mostly zero or short, now and then long.
    function automatic int gap_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    // Sends one character beat; valid always drops between beats, after a random gap.
    task automatic send_char(logic [1:0] md, logic [6:0] ch, logic lst,
        logic [31:0] f1, logic [31:0] r1, logic [31:0] l1,
        logic [31:0] f2, logic [31:0] r2, logic [31:0] l2);
        int g;
        g = gap_cycles();
        repeat (g + 1) @(negedge clk);
        mode <= md;
        char_code <= ch;
        last_char <= lst;
        first_forward <= f1;
        first_reverse <= r1;
        first_length <= l1;
        second_forward <= f2;
        second_reverse <= r2;
        second_length <= l2;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        fold_character();
        items_sent++;
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // Waits for every queued hash, then lets the block settle before a write.
    task automatic drain();
        while (pending_hashes.size() != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] value);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == RegModulus)
            cur_modulus = value;
        else
            cur_multiplier = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(0, 15);
            default: return $urandom();
        endcase
    endfunction

    // A random node string of one to max_chars characters; the last carries random children.
    task automatic send_node(int max_chars);
        int n;
        logic [1:0] md;
        n = $urandom_range(1, max_chars);
        md = $urandom_range(0, 9) < 2 ? 2'($urandom_range(2, 3)) : 2'($urandom_range(0, 1));
        for (int i = 0; i < n; i++)
            send_char((i == n - 1) ? md : 2'($urandom()), 7'($urandom()), i == n - 1,
                rand_word(), rand_word(), rand_word(),
                rand_word(), rand_word(), rand_word());
    endtask

    // Extremes of every field, every mode and the listed corner cases.
    task automatic test_directed();
        send_char(ModeLeaf, 7'h7F, 1'b1, '1, '1, '1, '1, '1, '1);
        send_char(ModeLeaf, 7'h00, 1'b1, 0, 0, 0, 0, 0, 0);
        send_char(ModeLeaf, 7'h2B, 1'b0, 0, 0, 0, 0, 0, 0);
        send_char(ModeUnary, 7'h2D, 1'b1, '1, '1, '1, '1, '1, '1);
        send_char(2'd2, 7'h2A, 1'b1, '1, '1, '1, '1, '1, '1);
        send_char(2'd3, 7'h2F, 1'b1, 32'h5555_5555, 32'hAAAA_AAAA, 7,
            32'h1234_5678, 32'h8765_4321, 3);
        send_char(2'd2, 7'h55, 1'b0, 0, 0, 0, 0, 0, 0);
        send_char(2'd2, 7'h2A, 1'b1, 32'd1000000007, 32'd1000000008, 0, 0, 1, 32'h8000_0000);
        send_char(ModeUnary, 7'h2A, 1'b1, 0, 0, 32'hFFFF_FFFE, 0, 0, 0);
    endtask

    task automatic test_config_sweep();
        logic [31:0] mods[4];
        logic [31:0] mults[4];
        mods = '{32'd2, 32'hFFFF_FFFF, 32'd0, 32'd65521};
        mults = '{32'd1, 32'hFFFF_FFFF, 32'd257, 32'd0};
        for (int s = 0; s < 4; s++)
        begin
            drain();
            write_reg(RegModulus, mods[s]);
            write_reg(RegMultiplier, mults[s]);
            for (int k = 0; k < 12; k++)
                send_node(4);
        end
        drain();
        write_reg(RegModulus, 32'd1000000007);
        write_reg(RegMultiplier, 32'd31);
    endtask

    task automatic test_random_nodes();
        int nodes;
        nodes = 0;
        while (items_sent < 1050)
        begin
            if (nodes % 75 == 74)
            begin
                drain();
                write_reg(RegModulus, 32'($urandom_range(2, 32'hFFFF_FFFF)));
                write_reg(RegMultiplier, $urandom() | 32'd1);
            end
            send_node(6);
            nodes++;
        end
    endtask

    // Output side: random stalls, with stall-free stretches, and the checker.
    always @(negedge clk)
    begin
        if ($urandom_range(0, 199) == 0)
            out_stall_on <= ~out_stall_on;
        out_ready <= out_stall_on ? ($urandom_range(0, 3) != 0 &&
            $urandom_range(0, 40) != 0) : 1'b1;
    end

    always @(posedge clk)
    begin
        node_hash_t h;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_hashes.size() == 0)
            begin
                report_mismatch("unexpected result beat", table_hash, 33'd0);
            end
            else
            begin
                h = pending_hashes.pop_front();
                if (forward_value !== h.fwd)
                    report_mismatch("forward_value", forward_value, h.fwd);
                if (reverse_value !== h.rev)
                    report_mismatch("reverse_value", reverse_value, h.rev);
                if (mixed_value !== h.mix)
                    report_mismatch("mixed_value", mixed_value, h.mix);
                if (total_length !== h.len)
                    report_mismatch("total_length", total_length, h.len);
                if (table_hash !== h.tab)
                    report_mismatch("table_hash", table_hash, h.tab);
            end
        end
    end

    // Watchdog: ends the run as a mismatch if it goes on far longer than binary nodes need.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > 20_000_000)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        mismatch_count = 0;
        items_sent = 0;
        cycle_count = 0;
        out_stall_on = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = RegModulus;
        cfg_data = 0;
        mode = ModeLeaf;
        char_code = 0;
        last_char = 0;
        first_forward = 0;
        first_reverse = 0;
        first_length = 0;
        second_forward = 0;
        second_reverse = 0;
        second_length = 0;
        cur_modulus = ModulusReset;
        cur_multiplier = MultiplierReset;
        clear_sums();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_config_sweep();
        test_random_nodes();
        drain();
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
